// ----- rtl/vtp_pkg.sv -----
// Shared types, widths and constants for the view transform and projection block.
package vtp_pkg;

  // Fixed-point widths
  localparam int PT_W       = 20;                     // world coordinate, Q12.8
  localparam int DIFF_W     = PT_W + 1;               // point minus eye
  localparam int COEF_W     = 16;                     // matrix entry, Q1.14
  localparam int PROD_W     = DIFF_W + COEF_W;        // one matrix product
  localparam int SUM_W      = PROD_W + 2;             // row dot product, Q.22
  localparam int MAG_W      = SUM_W - 2;              // |tx|, |ty| (fits by range)
  localparam int SCALE_W    = 24;                     // screen scale / view distance
  localparam int DIST_SHIFT = 14;                     // Q.8 distance to Q.22
  localparam int DEN_W      = SCALE_W + DIST_SHIFT;   // divisor width
  localparam int SPLIT      = 19;                     // low part of the scale multiply
  localparam int HI_W       = MAG_W - SPLIT;
  localparam int PLO_W      = SPLIT + SCALE_W;
  localparam int PHI_W      = HI_W + SCALE_W;
  localparam int NUM_W      = MAG_W + SCALE_W;        // dividend magnitude
  localparam int QUO_W      = 24;                     // quotient bits kept before clamp
  localparam int SCR_W      = 24;                     // screen coordinate, Q16.8
  localparam int NUM_COORD  = 3;

  localparam logic signed [SCR_W-1:0] SCR_MAX = {1'b0, {(SCR_W-1){1'b1}}};
  localparam logic signed [SCR_W-1:0] SCR_MIN = {1'b1, {(SCR_W-1){1'b0}}};

  // Pipeline depth
  localparam int PRE_STAGES  = 6;                     // subtract .. numerator
  localparam int DIV_STAGES  = QUO_W + 1;             // range check + one bit a stage
  localparam int LANE_STAGES = PRE_STAGES + DIV_STAGES + 1;
  localparam int N_STAGES    = LANE_STAGES + 1;       // plus output register

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 3 * PT_W;
  localparam int ROW_W      = 3 * COEF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERSPECTIVE_MODE = 3'd0,
    CFG_SCREEN_SCALE     = 3'd1,
    CFG_VIEW_DISTANCE    = 3'd2,
    CFG_EYE_POSITION     = 3'd3,
    CFG_ROT_ROW_X        = 3'd4,
    CFG_ROT_ROW_Y        = 3'd5,
    CFG_ROT_ROW_Z        = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                  perspective_mode;
    logic [SCALE_W-1:0]    screen_scale;
    logic [SCALE_W-1:0]    view_distance;
    logic [CFG_DATA_W-1:0] eye_position;
    logic [ROW_W-1:0]      rot_row_x;
    logic [ROW_W-1:0]      rot_row_y;
    logic [ROW_W-1:0]      rot_row_z;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    perspective_mode: 1'b1,
    screen_scale:     SCALE_W'(256),
    view_distance:    SCALE_W'(256),
    eye_position:     '0,
    rot_row_x:        ROW_W'(48'h0000_0000_4000),
    rot_row_y:        ROW_W'(48'h0000_4000_0000),
    rot_row_z:        ROW_W'(48'h4000_0000_0000)
  };

  // Channel payloads
  typedef struct packed {
    logic signed [PT_W-1:0] start_x;
    logic signed [PT_W-1:0] start_y;
    logic signed [PT_W-1:0] start_z;
    logic signed [PT_W-1:0] end_x;
    logic signed [PT_W-1:0] end_y;
    logic signed [PT_W-1:0] end_z;
  } vtp_in_t;

  typedef struct packed {
    logic signed [SCR_W-1:0] start_screen_x;
    logic signed [SCR_W-1:0] start_screen_y;
    logic signed [SCR_W-1:0] end_screen_x;
    logic signed [SCR_W-1:0] end_screen_y;
    logic                    start_depth_fault;
    logic                    end_depth_fault;
    logic                    saturated;
  } vtp_out_t;

  // Stage enables handed to each lane
  typedef struct packed {
    logic [LANE_STAGES-1:0] en;
  } lane_ctl_t;

  // What one lane reports for its point
  typedef struct packed {
    logic signed [SCR_W-1:0] sx;
    logic signed [SCR_W-1:0] sy;
    logic                    fault;
    logic                    sat;
  } lane_res_t;

endpackage

// ----- rtl/vtp_stream_if.sv -----
// Valid/ready stream channel carrying one payload of the given type.
interface vtp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/vtp_divider.sv -----
// Pipelined restoring divider: range check, then one quotient bit per stage.
module vtp_divider import vtp_pkg::*; #(
  parameter int NUM_W_P = NUM_W,
  parameter int DEN_W_P = DEN_W,
  parameter int QUO_W_P = QUO_W,
  parameter int SIDE_W  = 1
) (
  input  logic               clk,
  input  logic [QUO_W_P:0]   en,
  input  logic [NUM_W_P-1:0] num,
  input  logic [DEN_W_P-1:0] den,
  input  logic [SIDE_W-1:0]  side_in,
  output logic [QUO_W_P-1:0] quo,
  output logic               ovf,
  output logic [SIDE_W-1:0]  side_out
);

  localparam int SH_W = DEN_W_P + QUO_W_P;
  localparam int W    = (NUM_W_P > SH_W) ? NUM_W_P : SH_W;

  logic [W-1:0]       rem    [QUO_W_P];
  logic [DEN_W_P-1:0] den_r  [QUO_W_P];
  logic [QUO_W_P-1:0] quo_r  [QUO_W_P+1];
  logic               ovf_r  [QUO_W_P+1];
  logic [SIDE_W-1:0]  side_r [QUO_W_P+1];

  // Range check: quotient does not fit in QUO_W_P bits
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0]    <= W'(num);
      den_r[0]  <= den;
      quo_r[0]  <= '0;
      ovf_r[0]  <= W'(num) >= (W'(den) << QUO_W_P);
      side_r[0] <= side_in;
    end
  end

  // One compare-subtract per stage, most significant bit first
  for (genvar s = 1; s <= QUO_W_P; s++) begin : g_step
    localparam int J = QUO_W_P - s;
    logic [W-1:0] trial;
    logic         ge;

    assign trial = W'(den_r[s-1]) << J;
    assign ge    = rem[s-1] >= trial;

    always_ff @(posedge clk) begin
      if (en[s]) begin
        quo_r[s]  <= quo_r[s-1] | (ge ? (QUO_W_P'(1) << J) : '0);
        ovf_r[s]  <= ovf_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end

    if (s < QUO_W_P) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[s]) begin
          rem[s]   <= ge ? rem[s-1] - trial : rem[s-1];
          den_r[s] <= den_r[s-1];
        end
      end
    end
  end

  assign quo      = quo_r[QUO_W_P];
  assign ovf      = ovf_r[QUO_W_P];
  assign side_out = side_r[QUO_W_P];

endmodule

// ----- rtl/vtp_lane.sv -----
// One projection lane: eye offset, rotation, scale, divide and clamp for one point.
module vtp_lane import vtp_pkg::*; (
  input  logic                   clk,
  input  lane_ctl_t              ctl,
  input  cfg_t                   cfg,
  input  logic signed [PT_W-1:0] px,
  input  logic signed [PT_W-1:0] py,
  input  logic signed [PT_W-1:0] pz,
  output lane_res_t              res
);

  localparam int FIN = LANE_STAGES - 1;

  // Returns {sat, value}: sign applied, clamped to the screen range
  function automatic logic [SCR_W:0] clamp_coord(input logic [QUO_W-1:0] q,
                                                 input logic ovf, input logic neg);
    logic [QUO_W-1:0] limit;
    logic             over;
    logic [SCR_W-1:0] val;
    limit = neg ? QUO_W'(SCR_MAX) + QUO_W'(1) : QUO_W'(SCR_MAX);
    over  = ovf | (q > limit);
    if (over) begin
      val = neg ? SCR_MIN : SCR_MAX;
    end else begin
      val = neg ? SCR_W'(-q) : SCR_W'(q);
    end
    return {over, val};
  endfunction

  logic signed [PT_W-1:0]   pt   [NUM_COORD];
  logic [ROW_W-1:0]         rows [NUM_COORD];
  logic signed [COEF_W-1:0] coef [NUM_COORD][NUM_COORD];

  logic signed [DIFF_W-1:0] d    [NUM_COORD];
  logic signed [PROD_W-1:0] prod [NUM_COORD][NUM_COORD];
  logic signed [SUM_W-1:0]  t    [NUM_COORD];

  logic [MAG_W-1:0] mag [2];
  logic [PLO_W-1:0] plo [2];
  logic [PHI_W-1:0] phi [2];
  logic [NUM_W-1:0] num [2];
  logic [DEN_W-1:0] den3, den4, den5;
  logic [1:0]       neg3, neg4, neg5;
  logic             zero3, zero4, zero5;
  logic             fault3, fault4, fault5;
  logic             tz_nonpos;

  logic [QUO_W-1:0] qx, qy;
  logic             ovfx, ovfy;
  logic [2:0]       side_x;
  logic             side_y;
  logic [SCR_W:0]   cx, cy;

  assign pt[0]   = px;
  assign pt[1]   = py;
  assign pt[2]   = pz;
  assign rows[0] = cfg.rot_row_x;
  assign rows[1] = cfg.rot_row_y;
  assign rows[2] = cfg.rot_row_z;

  for (genvar r = 0; r < NUM_COORD; r++) begin : g_row
    for (genvar c = 0; c < NUM_COORD; c++) begin : g_col
      assign coef[r][c] = signed'(rows[r][COEF_W*c +: COEF_W]);
    end
  end

  // Stage 0: point minus eye
  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      for (int c = 0; c < NUM_COORD; c++) begin
        d[c] <= DIFF_W'(pt[c]) - DIFF_W'(signed'(cfg.eye_position[PT_W*c +: PT_W]));
      end
    end
  end

  // Stage 1: nine matrix products
  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      for (int r = 0; r < NUM_COORD; r++) begin
        for (int c = 0; c < NUM_COORD; c++) begin
          prod[r][c] <= PROD_W'(d[c]) * PROD_W'(coef[r][c]);
        end
      end
    end
  end

  // Stage 2: row sums, exact camera coordinates in Q.22
  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      for (int r = 0; r < NUM_COORD; r++) begin
        t[r] <= SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) + SUM_W'(prod[r][2]);
      end
    end
  end

  // Stage 3: magnitudes, divisor choice, depth checks
  assign tz_nonpos = t[2][SUM_W-1] | (t[2] == '0);

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      for (int r = 0; r < 2; r++) begin
        mag[r] <= MAG_W'(t[r][SUM_W-1] ? -t[r] : t[r]);
        neg3[r] <= t[r][SUM_W-1];
      end
      den3   <= cfg.perspective_mode ? DEN_W'(t[2])
                                     : DEN_W'(cfg.view_distance) << DIST_SHIFT;
      zero3  <= cfg.perspective_mode ? tz_nonpos : (cfg.view_distance == '0);
      fault3 <= cfg.perspective_mode & tz_nonpos;
    end
  end

  // Stage 4: scale multiply as two partial products
  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      for (int r = 0; r < 2; r++) begin
        plo[r] <= PLO_W'(mag[r][SPLIT-1:0]) * PLO_W'(cfg.screen_scale);
        phi[r] <= PHI_W'(mag[r][MAG_W-1:SPLIT]) * PHI_W'(cfg.screen_scale);
      end
      den4   <= den3;
      neg4   <= neg3;
      zero4  <= zero3;
      fault4 <= fault3;
    end
  end

  // Stage 5: join partial products into the dividend
  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      for (int r = 0; r < 2; r++) begin
        num[r] <= (NUM_W'(phi[r]) << SPLIT) + NUM_W'(plo[r]);
      end
      den5   <= den4;
      neg5   <= neg4;
      zero5  <= zero4;
      fault5 <= fault4;
    end
  end

  // Stages 6..30: x and y dividers share the divisor
  vtp_divider #(
    .NUM_W_P (NUM_W),
    .DEN_W_P (DEN_W),
    .QUO_W_P (QUO_W),
    .SIDE_W  (3)
  ) u_div_x (
    .clk      (clk),
    .en       (ctl.en[PRE_STAGES +: DIV_STAGES]),
    .num      (num[0]),
    .den      (den5),
    .side_in  ({neg5[0], zero5, fault5}),
    .quo      (qx),
    .ovf      (ovfx),
    .side_out (side_x)
  );

  vtp_divider #(
    .NUM_W_P (NUM_W),
    .DEN_W_P (DEN_W),
    .QUO_W_P (QUO_W),
    .SIDE_W  (1)
  ) u_div_y (
    .clk      (clk),
    .en       (ctl.en[PRE_STAGES +: DIV_STAGES]),
    .num      (num[1]),
    .den      (den5),
    .side_in  (neg5[1]),
    .quo      (qy),
    .ovf      (ovfy),
    .side_out (side_y)
  );

  // Final stage: sign, clamp, zero on bad divisor
  assign cx = clamp_coord(qx, ovfx, side_x[2]);
  assign cy = clamp_coord(qy, ovfy, side_y);

  always_ff @(posedge clk) begin
    if (ctl.en[FIN]) begin
      res.fault <= side_x[0];
      if (side_x[1]) begin
        res.sx  <= '0;
        res.sy  <= '0;
        res.sat <= 1'b0;
      end else begin
        res.sx  <= cx[SCR_W-1:0];
        res.sy  <= cy[SCR_W-1:0];
        res.sat <= cx[SCR_W] | cy[SCR_W];
      end
    end
  end

endmodule

// ----- rtl/view_transform_projection.sv -----
// Top level: configuration registers, pipeline control, two point lanes and result merge.
//
//   channel   dir  handshake            payload
//   item      in   item.valid/ready     start_x..end_z, signed Q12.8
//   result    out  result.valid/ready   screen x/y (Q16.8), depth faults, saturated
//   cfg       in   cfg_write            cfg_index, cfg_data (write only)
//
// One segment per cycle unless the result channel stalls. The deepest part of each lane
// is the 25-stage divider (range check, then one quotient bit a stage), one per screen
// coordinate.
// Reset (rst, synchronous) empties the pipeline and loads the identity view setup.
// A stalled result holds only the stages behind it that are occupied; empty stages
// keep filling, so item.ready drops only when every stage holds a request.
module view_transform_projection import vtp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  vtp_stream_if.sink            item,
  vtp_stream_if.source          result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int OUT = N_STAGES - 1;

  cfg_t                cfg, cfg_next;
  logic [N_STAGES-1:0] vld, hold, en;
  lane_ctl_t           lane_ctl;
  lane_res_t           res_start, res_end;

  // Configuration registers
  always_comb begin
    cfg_next = cfg;
    if (cfg_write) begin
      case (cfg_index)
        CFG_PERSPECTIVE_MODE: cfg_next.perspective_mode = cfg_data[0];
        CFG_SCREEN_SCALE:     cfg_next.screen_scale     = cfg_data[SCALE_W-1:0];
        CFG_VIEW_DISTANCE:    cfg_next.view_distance    = cfg_data[SCALE_W-1:0];
        CFG_EYE_POSITION:     cfg_next.eye_position     = cfg_data;
        CFG_ROT_ROW_X:        cfg_next.rot_row_x        = cfg_data[ROW_W-1:0];
        CFG_ROT_ROW_Y:        cfg_next.rot_row_y        = cfg_data[ROW_W-1:0];
        CFG_ROT_ROW_Z:        cfg_next.rot_row_z        = cfg_data[ROW_W-1:0];
        default:              cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else begin
      cfg <= cfg_next;
    end
  end

  // Stall chain: a stage holds when it is full and the one after it holds
  assign hold[OUT] = vld[OUT] & ~result.ready;
  for (genvar k = 0; k < OUT; k++) begin : g_hold
    assign hold[k] = vld[k] & hold[k+1];
  end
  assign en = ~hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= item.valid;
      for (int k = 1; k < N_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign item.ready   = en[0];
  assign result.valid = vld[OUT];
  assign lane_ctl.en  = en[LANE_STAGES-1:0];

  // Lanes: segment start and segment end
  vtp_lane u_lane_start (
    .clk (clk),
    .ctl (lane_ctl),
    .cfg (cfg),
    .px  (item.payload.start_x),
    .py  (item.payload.start_y),
    .pz  (item.payload.start_z),
    .res (res_start)
  );

  vtp_lane u_lane_end (
    .clk (clk),
    .ctl (lane_ctl),
    .cfg (cfg),
    .px  (item.payload.end_x),
    .py  (item.payload.end_y),
    .pz  (item.payload.end_z),
    .res (res_end)
  );

  // Merge lanes into the output register
  always_ff @(posedge clk) begin
    if (en[OUT]) begin
      result.payload.start_screen_x    <= res_start.sx;
      result.payload.start_screen_y    <= res_start.sy;
      result.payload.end_screen_x      <= res_end.sx;
      result.payload.end_screen_y      <= res_end.sy;
      result.payload.start_depth_fault <= res_start.fault;
      result.payload.end_depth_fault   <= res_end.fault;
      result.payload.saturated         <= res_start.sat | res_end.sat;
    end
  end

  // A depth fault zeroes that point's coordinates
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.payload.start_depth_fault |->
      result.payload.start_screen_x == '0 && result.payload.start_screen_y == '0)
    else $error("start depth fault with nonzero coordinates");

  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.payload.end_depth_fault |->
      result.payload.end_screen_x == '0 && result.payload.end_screen_y == '0)
    else $error("end depth fault with nonzero coordinates");

  // Saturation implies some coordinate sits on a range limit
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.payload.saturated |->
      (result.payload.start_screen_x == SCR_MAX || result.payload.start_screen_x == SCR_MIN ||
       result.payload.start_screen_y == SCR_MAX || result.payload.start_screen_y == SCR_MIN ||
       result.payload.end_screen_x == SCR_MAX || result.payload.end_screen_x == SCR_MIN ||
       result.payload.end_screen_y == SCR_MAX || result.payload.end_screen_y == SCR_MIN))
    else $error("saturated flag without a clamped coordinate");

  // A taken request occupies the first stage on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> vld[0])
    else $error("accepted request lost at pipeline entry");

endmodule
